### rtl/bgi_pkg.sv
// Shared types and constants of the bilinear grid interpolator.
// No dependencies; every other file in rtl except bgi_div imports this package.
package bgi_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned StepW    = 31;
  localparam int unsigned CountW   = 5;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CellW    = 8;
  localparam int unsigned TopW     = 41;
  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_X_ORIGIN    = 3'd0,
    CFG_X_STEP      = 3'd1,
    CFG_X_COUNT     = 3'd2,
    CFG_Y_ORIGIN    = 3'd3,
    CFG_Y_STEP      = 3'd4,
    CFG_Y_COUNT     = 3'd5,
    CFG_TABLE_VALID = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Per-item control carried alongside the coordinate path
  typedef struct packed {
    logic                   wr;
    logic                   zero;
    logic [IdxW-1:0]        wcol;
    logic [IdxW-1:0]        wrow;
    logic signed [ValW-1:0] wdata;
  } item_t;

  // Request to the banked grid memory
  typedef struct packed {
    logic                   rd;
    logic                   wr;
    logic [CellW-1:0]       ci;
    logic [CellW-1:0]       cj;
    logic [IdxW-1:0]        wcol;
    logic [IdxW-1:0]        wrow;
    logic signed [ValW-1:0] wdata;
  } mem_req_t;

endpackage

### rtl/bgi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing but its parameters; caller guarantees num < den << QW.
module bgi_div #(
  parameter int unsigned NW = 35,
  parameter int unsigned DW = 31,
  parameter int unsigned QW = 4,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [NW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [QW];
  logic [NW-1:0] rem_q   [QW];
  logic [DW-1:0] den_q   [QW];
  logic [QW-1:0] quo_q   [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Sh = QW - 1 - s;
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [NW-1:0] dsh;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign dsh = NW'(den_in) << Sh;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (rem_in - dsh) : rem_in;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_in | (ge ? (QW'(1) << Sh) : '0);
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### rtl/bgi_blend.sv
// One linear blend a + round((b - a) * f / s), ties toward +infinity.
// Uses bgi_div for the rounded quotient; imports bgi_pkg.
module bgi_blend #(
  parameter int unsigned SW = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [bgi_pkg::ValW-1:0]   a_i,
  input  logic signed [bgi_pkg::ValW-1:0]   b_i,
  input  logic        [bgi_pkg::StepW-1:0]  f_i,
  input  logic        [bgi_pkg::StepW-1:0]  s_i,
  input  logic        [SW-1:0]              side_i,
  output logic                              valid_o,
  output logic signed [bgi_pkg::ValW-1:0]   y_o,
  output logic        [SW-1:0]              side_o
);
  import bgi_pkg::*;

  localparam int unsigned NumW = 2 * ValW + 1;
  localparam int unsigned DenW = StepW + 1;
  localparam int unsigned DSW  = ValW + 1 + SW;

  logic signed [ValW:0]     diff;
  logic signed [NumW-1:0]   prod;
  logic                     v1_q, v2_q, v4_q;
  logic signed [ValW-1:0]   a1_q, a2_q, y_q;
  logic [StepW-1:0]         s1_q;
  logic signed [2*ValW-1:0] p1_q;
  logic [SW-1:0]            side1_q, side2_q, side4_q;
  logic                     neg;
  logic [2*ValW-1:0]        mag;
  logic [NumW-1:0]          num2_q;
  logic [DenW-1:0]          den2_q;
  logic                     neg2_q;
  logic                     dv;
  logic [ValW-1:0]          dq;
  logic [DSW-1:0]           dside;
  logic signed [ValW-1:0]   da;
  logic                     dneg;
  logic [SW-1:0]            dsd;
  logic signed [ValW+1:0]   sum;

  assign diff = (ValW+1)'(b_i) - (ValW+1)'(a_i);
  assign prod = diff * $signed({1'b0, f_i});

  // Sign and magnitude so the divider stays unsigned
  assign neg = p1_q[2*ValW-1];
  assign mag = neg ? (2*ValW)'(-p1_q) : p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v4_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a_i;
      s1_q    <= s_i;
      p1_q    <= prod[2*ValW-1:0];
      side1_q <= side_i;
      a2_q    <= a1_q;
      neg2_q  <= neg;
      num2_q  <= {mag, 1'b0} + NumW'(s1_q) - NumW'(neg);
      den2_q  <= {s1_q, 1'b0};
      side2_q <= side1_q;
      y_q     <= sum[ValW-1:0];
      side4_q <= dsd;
    end
  end

  bgi_div #(
    .NW(NumW),
    .DW(DenW),
    .QW(ValW),
    .SW(DSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v2_q),
    .num_i   (num2_q),
    .den_i   (den2_q),
    .side_i  ({a2_q, neg2_q, side2_q}),
    .valid_o (dv),
    .quo_o   (dq),
    .rem_o   (),
    .side_o  (dside)
  );

  assign {da, dneg, dsd} = dside;
  assign sum = (ValW+2)'(da) + (dneg ? -$signed({2'b00, dq}) : $signed({2'b00, dq}));

  assign valid_o = v4_q;
  assign y_o     = y_q;
  assign side_o  = side4_q;

endmodule

### rtl/bgi_mem.sv
// Grid table in four banks split by row and column parity, so the four
// corners of a cell are read in the same cycle. Imports bgi_pkg.
module bgi_mem #(
  parameter int unsigned GRID_COLUMNS = 16,
  parameter int unsigned GRID_ROWS    = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  bgi_pkg::mem_req_t               req_i,
  output logic signed [bgi_pkg::ValW-1:0] v00_o,
  output logic signed [bgi_pkg::ValW-1:0] v01_o,
  output logic signed [bgi_pkg::ValW-1:0] v10_o,
  output logic signed [bgi_pkg::ValW-1:0] v11_o
);
  import bgi_pkg::*;

  localparam int unsigned HalfC = (GRID_COLUMNS + 1) / 2;
  localparam int unsigned HalfR = (GRID_ROWS + 1) / 2;
  localparam int unsigned Depth = HalfC * HalfR;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic signed [ValW-1:0] rd_q [4];
  logic [1:0]             par_q;
  logic                   in_range;
  logic [15:0]            waddr;

  assign in_range = (16'(req_i.wcol) < 16'(GRID_COLUMNS)) && (16'(req_i.wrow) < 16'(GRID_ROWS));
  assign waddr    = 16'(req_i.wrow >> 1) * 16'(HalfC) + 16'(req_i.wcol >> 1);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic Pr = 1'((b >> 1) & 1);
    localparam logic Pc = 1'(b & 1);
    logic signed [ValW-1:0] mem [Depth];
    logic [CellW:0]         rsel, csel;
    logic [15:0]            raddr;
    logic                   we;

    assign rsel  = (req_i.cj[0] == Pr) ? (CellW+1)'(req_i.cj) : (CellW+1)'(req_i.cj) + 1'b1;
    assign csel  = (req_i.ci[0] == Pc) ? (CellW+1)'(req_i.ci) : (CellW+1)'(req_i.ci) + 1'b1;
    assign raddr = 16'(rsel >> 1) * 16'(HalfC) + 16'(csel >> 1);
    assign we    = en_i && req_i.wr && in_range &&
                   (req_i.wrow[0] == Pr) && (req_i.wcol[0] == Pc);

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr[AW-1:0]] <= req_i.wdata;
      end
      if (en_i && req_i.rd) begin
        rd_q[b] <= mem[raddr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par_q <= {req_i.cj[0], req_i.ci[0]};
    end
  end

  assign v00_o = rd_q[{ par_q[1],  par_q[0]}];
  assign v01_o = rd_q[{ par_q[1], ~par_q[0]}];
  assign v10_o = rd_q[{~par_q[1],  par_q[0]}];
  assign v11_o = rd_q[{~par_q[1], ~par_q[0]}];

endmodule

### rtl/bilinear_grid_interpolator.sv
// Bilinear grid interpolator. Throughput: one item per cycle; writes and queries share one
// in-order pipeline. The result path ends in a two-entry queue, so the pipe only holds
// when it is full. Reset (rst_ni low, asynchronous) empties the pipe and the queue and
// restores register defaults; grid contents are not cleared and stay undefined until written.
module bilinear_grid_interpolator #(
  parameter int unsigned GRID_COLUMNS = 16,
  parameter int unsigned GRID_ROWS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [bgi_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [bgi_pkg::ValW-1:0]           cfg_wdata_i,
  // input item channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic signed [bgi_pkg::ValW-1:0]    x_coord_i,
  input  logic signed [bgi_pkg::ValW-1:0]    y_coord_i,
  input  logic [bgi_pkg::IdxW-1:0]           column_index_i,
  input  logic [bgi_pkg::IdxW-1:0]           row_index_i,
  input  logic signed [bgi_pkg::ValW-1:0]    entry_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bgi_pkg::ValW-1:0]    interpolated_value_o
);
  import bgi_pkg::*;

  localparam int unsigned QXW = $clog2(GRID_COLUMNS);
  localparam int unsigned QYW = $clog2(GRID_ROWS);
  localparam int unsigned QL  = (QXW > QYW) ? QXW : QYW;  // cell index bits
  localparam int unsigned NW  = StepW + QL;               // offset-from-origin width
  localparam int unsigned CXW = $clog2(GRID_COLUMNS + 1);
  localparam int unsigned CYW = $clog2(GRID_ROWS + 1);
  localparam int unsigned IW  = $bits(item_t);
  localparam int unsigned SpW = StepW + CellW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [ValW-1:0]   x_origin_q, y_origin_q;
  logic [StepW-1:0]         x_step_q, y_step_q;
  logic [CountW-1:0]        x_count_q, y_count_q;
  logic                     table_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q    <= '0;
      x_step_q      <= StepW'(65536);
      x_count_q     <= CountW'(2);
      y_origin_q    <= '0;
      y_step_q      <= StepW'(65536);
      y_count_q     <= CountW'(2);
      table_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_X_ORIGIN:    x_origin_q    <= cfg_wdata_i;
        CFG_X_STEP:      x_step_q      <= cfg_wdata_i[StepW-1:0];
        CFG_X_COUNT:     x_count_q     <= cfg_wdata_i[CountW-1:0];
        CFG_Y_ORIGIN:    y_origin_q    <= cfg_wdata_i;
        CFG_Y_STEP:      y_step_q      <= cfg_wdata_i[StepW-1:0];
        CFG_Y_COUNT:     y_count_q     <= cfg_wdata_i[CountW-1:0];
        CFG_TABLE_VALID: table_valid_q <= cfg_wdata_i[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Effective step (zero acts as one) and count clamped to [2, grid size]
  logic [StepW-1:0] sx, sy;
  logic [CXW-1:0]   nx;
  logic [CYW-1:0]   ny;

  assign sx = (x_step_q == '0) ? StepW'(1) : x_step_q;
  assign sy = (y_step_q == '0) ? StepW'(1) : y_step_q;

  always_comb begin
    if (x_count_q < CountW'(2)) begin
      nx = CXW'(2);
    end else if (9'(x_count_q) > 9'(GRID_COLUMNS)) begin
      nx = CXW'(GRID_COLUMNS);
    end else begin
      nx = CXW'(x_count_q);
    end
    if (y_count_q < CountW'(2)) begin
      ny = CYW'(2);
    end else if (9'(y_count_q) > 9'(GRID_ROWS)) begin
      ny = CYW'(GRID_ROWS);
    end else begin
      ny = CYW'(y_count_q);
    end
  end

  // Far edge of the grid, origin + step * (count - 1); registered, so it follows the registers
  // in the next cycle, which the idle time around configuration writes covers.
  logic [SpW-1:0]         spanx, spany;
  logic signed [TopW-1:0] topx_q, topy_q;

  assign spanx = SpW'(sx) * SpW'(nx - CXW'(1));
  assign spany = SpW'(sy) * SpW'(ny - CYW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topx_q <= TopW'(65536);
      topy_q <= TopW'(65536);
    end else begin
      topx_q <= TopW'(x_origin_q) + $signed(TopW'(spanx));
      topy_q <= TopW'(y_origin_q) + $signed(TopW'(spany));
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: whole pipe advances together, held only when the result
  // queue is full and its head is not being taken.
  // ---------------------------------------------------------------------------
  logic       en;
  logic       acc;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop        = out_valid_o && !out_stall_i;
  assign en         = (cnt_q != 2'd2) || pop;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // ---------------------------------------------------------------------------
  // Stage A: clamp the point into the grid rectangle, take offset from origin
  // ---------------------------------------------------------------------------
  logic signed [TopW-1:0] cx, cy, ox, oy, ccx, ccy, dx, dy;
  item_t                  item_in;
  logic                   a_valid_q;
  logic [NW-1:0]          a_dx_q, a_dy_q;
  item_t                  a_item_q;

  assign cx  = TopW'(x_coord_i);
  assign cy  = TopW'(y_coord_i);
  assign ox  = TopW'(x_origin_q);
  assign oy  = TopW'(y_origin_q);
  assign ccx = (cx < ox) ? ox : ((cx > topx_q) ? topx_q : cx);
  assign ccy = (cy < oy) ? oy : ((cy > topy_q) ? topy_q : cy);
  assign dx  = ccx - ox;
  assign dy  = ccy - oy;

  assign item_in.wr    = (op_e'(operation_i) == OP_WRITE);
  assign item_in.zero  = !table_valid_q;
  assign item_in.wcol  = column_index_i;
  assign item_in.wrow  = row_index_i;
  assign item_in.wdata = entry_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q   <= dx[NW-1:0];
      a_dy_q   <= dy[NW-1:0];
      a_item_q <= item_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell search: offset / step on both axes in matching pipelined dividers
  // ---------------------------------------------------------------------------
  logic          xd_valid;
  logic [QL-1:0] kx, ky;
  logic [NW-1:0] remx, remy;
  logic [IW-1:0] xd_side;

  bgi_div #(.NW(NW), .DW(StepW), .QW(QL), .SW(IW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .num_i   (a_dx_q),
    .den_i   (sx),
    .side_i  (a_item_q),
    .valid_o (xd_valid),
    .quo_o   (kx),
    .rem_o   (remx),
    .side_o  (xd_side)
  );

  bgi_div #(.NW(NW), .DW(StepW), .QW(QL), .SW(1)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .num_i   (a_dy_q),
    .den_i   (sy),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (ky),
    .rem_o   (remy),
    .side_o  ()
  );

  // ---------------------------------------------------------------------------
  // Stage F: clamp the cell to count - 2; on the far edge the offset is a full step
  // ---------------------------------------------------------------------------
  logic [CellW:0]   kx9, ky9, limx, limy, cix, ciy;
  logic             clx, cly;
  logic [StepW-1:0] fx, fy;
  logic             f_valid_q;
  item_t            f_item_q;
  logic [CellW-1:0] f_ci_q, f_cj_q;
  logic [StepW-1:0] f_fx_q, f_fy_q;

  assign kx9  = (CellW+1)'(kx);
  assign ky9  = (CellW+1)'(ky);
  assign limx = (CellW+1)'(nx) - (CellW+1)'(2);
  assign limy = (CellW+1)'(ny) - (CellW+1)'(2);
  assign clx  = kx9 > limx;
  assign cly  = ky9 > limy;
  assign cix  = clx ? limx : kx9;
  assign ciy  = cly ? limy : ky9;
  assign fx   = remx[StepW-1:0] + (clx ? sx : '0);
  assign fy   = remy[StepW-1:0] + (cly ? sy : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= xd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_item_q <= item_t'(xd_side);
      f_ci_q   <= cix[CellW-1:0];
      f_cj_q   <= ciy[CellW-1:0];
      f_fx_q   <= fx;
      f_fy_q   <= fy;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: grid memory. Writes and reads happen at this one stage in item
  // order, so a query always sees every earlier write without forwarding.
  // ---------------------------------------------------------------------------
  mem_req_t               req;
  logic signed [ValW-1:0] v00, v01, v10, v11;
  logic                   m_valid_q, m_zero_q;
  logic [StepW-1:0]       m_fx_q, m_fy_q;

  assign req.rd    = f_valid_q && !f_item_q.wr;
  assign req.wr    = f_valid_q && f_item_q.wr;
  assign req.ci    = f_ci_q;
  assign req.cj    = f_cj_q;
  assign req.wcol  = f_item_q.wcol;
  assign req.wrow  = f_item_q.wrow;
  assign req.wdata = f_item_q.wdata;

  bgi_mem #(.GRID_COLUMNS(GRID_COLUMNS), .GRID_ROWS(GRID_ROWS)) u_mem (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (req),
    .v00_o (v00),
    .v01_o (v01),
    .v10_o (v10),
    .v11_o (v11)
  );

  // Writes retire here; only queries go on to the blend
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= req.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_zero_q <= f_item_q.zero;
      m_fx_q   <= f_fx_q;
      m_fy_q   <= f_fy_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Separable blend: along x on both rows, then along y
  // ---------------------------------------------------------------------------
  logic                   b0_valid;
  logic signed [ValW-1:0] r0, r1, yv;
  logic [StepW:0]         b0_side;
  logic                   b2_valid;
  logic                   b2_zero;

  bgi_blend #(.SW(StepW + 1)) u_blend_r0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid_q),
    .a_i     (v00),
    .b_i     (v01),
    .f_i     (m_fx_q),
    .s_i     (sx),
    .side_i  ({m_zero_q, m_fy_q}),
    .valid_o (b0_valid),
    .y_o     (r0),
    .side_o  (b0_side)
  );

  bgi_blend #(.SW(1)) u_blend_r1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid_q),
    .a_i     (v10),
    .b_i     (v11),
    .f_i     (m_fx_q),
    .s_i     (sx),
    .side_i  (1'b0),
    .valid_o (),
    .y_o     (r1),
    .side_o  ()
  );

  bgi_blend #(.SW(1)) u_blend_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b0_valid),
    .a_i     (r0),
    .b_i     (r1),
    .f_i     (b0_side[StepW-1:0]),
    .s_i     (sy),
    .side_i  (b0_side[StepW]),
    .valid_o (b2_valid),
    .y_o     (yv),
    .side_o  (b2_zero)
  );

  // ---------------------------------------------------------------------------
  // Result queue, two entries
  // ---------------------------------------------------------------------------
  logic signed [ValW-1:0] buf_q [2];
  logic                   wp_q, rp_q;
  logic                   push;

  assign push = en && b2_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= b2_zero ? '0 : yv;
    end
  end

  assign out_valid_o          = (cnt_q != 2'd0);
  assign interpolated_value_o = buf_q[rp_q];

endmodule

### rtl/bgi_chk.sv
// Port-level checks for bilinear_grid_interpolator, attached by bind.
// Imports bgi_pkg for field widths.
module bgi_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [bgi_pkg::ValW-1:0] interpolated_value_o
);
  import bgi_pkg::*;

  // A held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interpolated_value_o))
    else $error("result changed while stalled");

  // Input only holds back when the result queue is full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // Input is never stalled while the result queue is empty
  a_no_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o && (in_valid_i || !in_valid_i))
    else $error("stall raised with empty result queue");

endmodule

bind bilinear_grid_interpolator bgi_chk u_bgi_chk (.*);
